>>> rtl/core/cspf_pkg.sv
// cosine similarity pair filter: shared types and constants
// command, configuration and result records; no dependencies
package cspf_pkg;

	localparam int ID_W        = 32;
	localparam int COMP_IN_W   = 16;
	localparam int NCOMP_IN    = 4;
	localparam int ROW_W       = 6;
	localparam int THR_W       = 15;
	localparam int ACT_W       = 2;
	localparam int QDEPTH      = 2;
	localparam int FRAC_SHIFT  = 15;
	localparam int SQ_SHIFT    = 30;

	localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_EXCLUDE   = 1'b1;

	localparam logic [THR_W-1:0] THR_RESET = 15'd29491;
	localparam logic [THR_W-1:0] EXC_RESET = 15'd32767;
	localparam logic [THR_W-1:0] COS_MAX   = 15'd32767;

	typedef struct packed {
		logic [ACT_W-1:0]                     action;
		logic [ID_W-1:0]                      user_id;
		logic [NCOMP_IN-1:0][COMP_IN_W-1:0]   comp;
		logic [ROW_W-1:0]                     row;
	} cmd_t;

	typedef struct packed {
		logic [THR_W-1:0] match_threshold;
		logic [THR_W-1:0] exclude_bound;
	} cfg_t;

	typedef struct packed {
		logic [ID_W-1:0]  row_user;
		logic [ID_W-1:0]  col_user;
		logic [THR_W-1:0] cosine;
		logic             valid_res;
		logic             last;
	} res_t;

endpackage

>>> rtl/core/cspf_cmd_queue.sv
// front end: accepts commands while not full, drops unknown actions, queues the rest
// uses cspf_pkg
module cspf_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cspf_pkg::cmd_t cmd_in,
	input  logic          pop,
	output logic          busy,
	output logic          head_valid,
	output cspf_pkg::cmd_t head
);
	import cspf_pkg::*;

	localparam int QAW = $clog2(QDEPTH);
	localparam int QFW = $clog2(QDEPTH + 1);

	cmd_t           slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QFW-1:0] fill_q;
	logic           push;
	logic           known;

	always_comb begin
		case (cmd_in.action) inside
			ACT_LOAD, ACT_QUERY, ACT_CLEAR: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	assign busy       = (fill_q == QFW'(QDEPTH));
	assign push       = start && !busy && known;
	assign head_valid = (fill_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= cmd_in;
	end

endmodule

>>> rtl/core/cspf_seq_mul.sv
// shift-add multiplier, one multiplier bit per cycle
// no package dependency
module cspf_seq_mul #(
	parameter int A_W = 65,
	parameter int B_W = 33
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] p
);
	localparam int P_W = A_W + B_W;
	localparam int CNW = $clog2(B_W + 1);

	logic           run_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [P_W-1:0] mcand_q;
	logic [B_W-1:0] mplier_q;
	logic [P_W-1:0] acc_q;

	assign done = done_q;
	assign p    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNW'(B_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= P_W'(a);
			mplier_q <= b;
			acc_q    <= '0;
		end else if (run_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

endmodule

>>> rtl/core/cspf_root_div.sv
// iterative unit: floor square root (one root bit a cycle) and
// restoring division (one quotient bit a cycle); no package dependency
module cspf_root_div #(
	parameter int R_W   = 33,
	parameter int NUM_W = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sqrt_start,
	input  logic [2*R_W-1:0]   radicand,
	input  logic               div_start,
	input  logic [NUM_W-1:0]   num,
	input  logic [R_W-1:0]     den,
	output logic               done,
	output logic [R_W-1:0]     root,
	output logic [NUM_W-1:0]   quot
);
	localparam int CNW = $clog2(NUM_W + R_W + 1);
	localparam logic MODE_SQRT = 1'b0;
	localparam logic MODE_DIV  = 1'b1;

	logic             run_q;
	logic             done_q;
	logic             mode_q;
	logic [CNW-1:0]   cnt_q;
	logic [2*R_W-1:0] x_q;
	logic [R_W+1:0]   rem_q;
	logic [R_W-1:0]   root_q;
	logic [NUM_W-1:0] n_q;
	logic [R_W-1:0]   drem_q;
	logic [R_W-1:0]   den_q;
	logic [R_W+1:0]   rem_sh;
	logic [R_W+1:0]   trial;
	logic             sq_ge;
	logic [R_W:0]     dsh;
	logic             dv_ge;
	logic [R_W:0]     dsub;

	assign done = done_q;
	assign root = root_q;
	assign quot = n_q;

	always_comb begin
		rem_sh = {rem_q[R_W-1:0], x_q[2*R_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		sq_ge  = (rem_sh >= trial);
		dsh    = {drem_q, n_q[NUM_W-1]};
		dv_ge  = (dsh >= {1'b0, den_q});
		dsub   = dsh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			mode_q <= MODE_SQRT;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (sqrt_start) begin
				run_q  <= 1'b1;
				mode_q <= MODE_SQRT;
				cnt_q  <= CNW'(R_W);
			end else if (div_start) begin
				run_q  <= 1'b1;
				mode_q <= MODE_DIV;
				cnt_q  <= CNW'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sqrt_start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (div_start) begin
			n_q    <= num;
			drem_q <= '0;
			den_q  <= den;
		end else if (run_q) begin
			if (mode_q == MODE_SQRT) begin
				x_q    <= x_q << 2;
				rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[R_W-2:0], sq_ge};
			end else begin
				// remainder stays below the divisor, so its low bits suffice
				drem_q <= dv_ge ? dsub[R_W-1:0] : dsh[R_W-1:0];
				n_q    <= {n_q[NUM_W-2:0], dv_ge};
			end
		end
	end

endmodule

>>> rtl/core/cspf_exec.sv
// back end: entry table, query sequencer and result register
// uses cspf_pkg, cspf_seq_mul, cspf_root_div
module cspf_exec #(
	parameter int MAX_ENTRIES = 64,
	parameter int VECTOR_DIM  = 4,
	parameter int COMP_BITS   = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  cspf_pkg::cmd_t head,
	input  cspf_pkg::cfg_t cfg,
	output logic           pop,
	output logic           res_strobe,
	output cspf_pkg::res_t res
);
	import cspf_pkg::*;

	localparam int CB   = COMP_BITS;
	localparam int DIM  = VECTOR_DIM;
	localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int KW   = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int DW   = 2 * CB + 2;
	localparam int NW   = 2 * CB + 1;
	localparam int PW   = 4 * CB + 1;
	localparam int MB   = (NW > 2 * THR_W) ? NW : 2 * THR_W;
	localparam int LW   = PW + MB;
	localparam int RW   = (PW + 1) / 2;
	localparam int NUMW = NW + FRAC_SHIFT;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ROW   = 4'd1;
	localparam logic [3:0] S_COL   = 4'd2;
	localparam logic [3:0] S_DOT   = 4'd3;
	localparam logic [3:0] S_CHECK = 4'd4;
	localparam logic [3:0] S_MPROD = 4'd5;
	localparam logic [3:0] S_MDOT  = 4'd6;
	localparam logic [3:0] S_MLO   = 4'd7;
	localparam logic [3:0] S_MHI   = 4'd8;
	localparam logic [3:0] S_SQRT  = 4'd9;
	localparam logic [3:0] S_DIV   = 4'd10;
	localparam logic [3:0] S_NEXT  = 4'd11;

	logic [3:0]             state_q;
	logic [CW-1:0]          count_q;
	logic                   pend_q;
	logic                   res_strobe_q;
	res_t                   res_q;

	logic [ID_W-1:0]        id_mem  [MAX_ENTRIES];
	logic [DIM-1:0][CB-1:0] vec_mem [MAX_ENTRIES];
	logic [ID_W-1:0]        rd_id_q;
	logic [DIM-1:0][CB-1:0] rd_vec_q;
	logic [AW-1:0]          rd_addr;
	logic                   mem_we;
	logic [DIM-1:0][CB-1:0] wr_vec;

	logic [DIM-1:0][CB-1:0] a_vec_q;
	logic [DIM-1:0][CB-1:0] b_vec_q;
	logic [ID_W-1:0]        rid_q;
	logic [ID_W-1:0]        cid_q;
	logic [AW-1:0]          q_idx_q;
	logic [KW-1:0]          k_q;
	logic signed [DW-1:0]   dot_q;
	logic [NW-1:0]          a2_q;
	logic [NW-1:0]          b2_q;
	logic [PW-1:0]          prod_q;
	logic [LW-1:0]          lhs_q;
	logic [ID_W-1:0]        pend_id_q;
	logic [THR_W-1:0]       pend_cos_q;

	logic                   is_load;
	logic                   is_query;
	logic                   is_clear;
	logic                   row_ok;
	logic                   cand_ok;
	logic                   last_col;
	logic signed [CB-1:0]   xa;
	logic signed [CB-1:0]   xb;
	logic signed [2*CB-1:0] p_ab;
	logic signed [2*CB-1:0] p_aa;
	logic signed [2*CB-1:0] p_bb;
	logic [2*THR_W-1:0]     thr2;
	logic [2*THR_W-1:0]     upp2;

	logic                   mul_start;
	logic [PW-1:0]          mul_a;
	logic [MB-1:0]          mul_b;
	logic                   mul_done;
	logic [LW-1:0]          mul_p;
	logic                   lo_pass;
	logic                   hi_pass;
	logic                   sqrt_start;
	logic                   div_start;
	logic                   rd_done;
	logic [RW-1:0]          rd_root;
	logic [NUMW-1:0]        rd_quot;
	logic [THR_W-1:0]       cos_sat;

	assign is_load  = head_valid && (head.action == ACT_LOAD);
	assign is_query = head_valid && (head.action == ACT_QUERY);
	assign is_clear = head_valid && (head.action == ACT_CLEAR);
	assign pop      = (state_q == S_IDLE) && head_valid;
	assign row_ok   = {1'b0, head.row} < (ROW_W + 1)'(count_q);
	assign mem_we   = (state_q == S_IDLE) && is_load && (count_q < CW'(MAX_ENTRIES));
	assign last_col = (CW'(q_idx_q) + 1'b1) >= count_q;

	always_comb begin
		for (int k = 0; k < DIM; k++) wr_vec[k] = head.comp[k][CB-1:0];
	end

	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = head.row[AW-1:0];
			S_ROW:   rd_addr = '0;
			default: rd_addr = q_idx_q + 1'b1;
		endcase
	end

	// one component step of the dot product and both squared norms
	always_comb begin
		xa   = $signed(a_vec_q[k_q]);
		xb   = $signed(b_vec_q[k_q]);
		p_ab = (2 * CB)'(xa) * (2 * CB)'(xb);
		p_aa = (2 * CB)'(xa) * (2 * CB)'(xa);
		p_bb = (2 * CB)'(xb) * (2 * CB)'(xb);
	end

	assign cand_ok = !dot_q[DW-1] && (dot_q != '0) && (a2_q != '0) && (b2_q != '0);
	assign thr2    = (2 * THR_W)'(cfg.match_threshold) * (2 * THR_W)'(cfg.match_threshold);
	assign upp2    = (2 * THR_W)'(cfg.exclude_bound) * (2 * THR_W)'(cfg.exclude_bound);
	assign lo_pass = lhs_q > mul_p;
	assign hi_pass = lhs_q < mul_p;

	always_comb begin
		case (state_q)
			S_CHECK: begin
				mul_a = PW'(a2_q);
				mul_b = MB'(b2_q);
			end
			S_MPROD: begin
				mul_a = PW'(dot_q[NW-1:0]);
				mul_b = MB'(dot_q[NW-1:0]);
			end
			S_MDOT: begin
				mul_a = prod_q;
				mul_b = MB'(thr2);
			end
			default: begin
				mul_a = prod_q;
				mul_b = MB'(upp2);
			end
		endcase
	end

	assign mul_start = ((state_q == S_CHECK) && cand_ok) ||
		((state_q == S_MPROD) && mul_done) ||
		((state_q == S_MDOT) && mul_done) ||
		((state_q == S_MLO) && mul_done && lo_pass);
	assign sqrt_start = (state_q == S_MHI) && mul_done && hi_pass;
	assign div_start  = (state_q == S_SQRT) && rd_done;
	assign cos_sat    = (rd_quot > NUMW'(COS_MAX)) ? COS_MAX : rd_quot[THR_W-1:0];

	cspf_seq_mul #(
		.A_W(PW),
		.B_W(MB)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.p     (mul_p)
	);

	cspf_root_div #(
		.R_W  (RW),
		.NUM_W(NUMW)
	) u_root_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.sqrt_start(sqrt_start),
		.radicand  ((2 * RW)'(prod_q)),
		.div_start (div_start),
		.num       ({dot_q[NW-1:0], {FRAC_SHIFT{1'b0}}}),
		.den       (rd_root),
		.done      (rd_done),
		.root      (rd_root),
		.quot      (rd_quot)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			id_mem[count_q[AW-1:0]]  <= head.user_id;
			vec_mem[count_q[AW-1:0]] <= wr_vec;
		end
		rd_id_q  <= id_mem[rd_addr];
		rd_vec_q <= vec_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pend_q       <= 1'b0;
			res_strobe_q <= 1'b0;
		end else begin
			res_strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (mem_we) count_q <= count_q + 1'b1;
					if (is_clear) count_q <= '0;
					if (is_query) begin
						if (row_ok) state_q <= S_ROW;
						else res_strobe_q <= 1'b1;
					end
				end
				S_ROW: begin
					pend_q  <= 1'b0;
					state_q <= S_COL;
				end
				S_COL: state_q <= S_DOT;
				S_DOT: if (k_q == KW'(DIM - 1)) state_q <= S_CHECK;
				S_CHECK: state_q <= cand_ok ? S_MPROD : S_NEXT;
				S_MPROD: if (mul_done) state_q <= S_MDOT;
				S_MDOT: if (mul_done) state_q <= S_MLO;
				S_MLO: if (mul_done) state_q <= lo_pass ? S_MHI : S_NEXT;
				S_MHI: if (mul_done) state_q <= hi_pass ? S_SQRT : S_NEXT;
				S_SQRT: if (rd_done) state_q <= S_DIV;
				S_DIV: begin
					if (rd_done) begin
						// the previous match is now known not to be the last one
						if (pend_q) res_strobe_q <= 1'b1;
						pend_q  <= 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (last_col) begin
						res_strobe_q <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_COL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_q <= '{row_user: '0, col_user: '0, cosine: '0, valid_res: 1'b0,
					last: 1'b1};
			end
			S_ROW: begin
				a_vec_q <= rd_vec_q;
				rid_q   <= rd_id_q;
				q_idx_q <= '0;
			end
			S_COL: begin
				b_vec_q <= rd_vec_q;
				cid_q   <= rd_id_q;
				k_q     <= '0;
				dot_q   <= '0;
				a2_q    <= '0;
				b2_q    <= '0;
			end
			S_DOT: begin
				dot_q <= dot_q + DW'(p_ab);
				a2_q  <= a2_q + NW'($unsigned(p_aa));
				b2_q  <= b2_q + NW'($unsigned(p_bb));
				k_q   <= k_q + 1'b1;
			end
			S_MPROD: if (mul_done) prod_q <= mul_p[PW-1:0];
			S_MDOT: if (mul_done) lhs_q <= mul_p << SQ_SHIFT;
			S_DIV: begin
				if (rd_done) begin
					res_q <= '{row_user: rid_q, col_user: pend_id_q, cosine: pend_cos_q,
						valid_res: 1'b1, last: 1'b0};
					pend_id_q  <= cid_q;
					pend_cos_q <= cos_sat;
				end
			end
			S_NEXT: begin
				q_idx_q <= q_idx_q + 1'b1;
				if (pend_q) begin
					res_q <= '{row_user: rid_q, col_user: pend_id_q, cosine: pend_cos_q,
						valid_res: 1'b1, last: 1'b1};
				end else begin
					res_q <= '{row_user: rid_q, col_user: '0, cosine: '0, valid_res: 1'b0,
						last: 1'b1};
				end
			end
			default: ;
		endcase
	end

	assign res_strobe = res_strobe_q;
	assign res        = res_q;

	a_last_ends_query: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe_q && res_q.last |-> state_q == S_IDLE)
		else $error("final result seen while a query is still running");

	a_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe_q && !res_q.last |-> state_q == S_NEXT && pend_q)
		else $error("non-final result outside the match path");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe_q && !res_q.valid_res |-> res_q.last)
		else $error("empty result not marked last");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

endmodule

>>> rtl/core/cosine_similarity_pair_filter.sv
// cosine similarity pair filter, top level: ports, config registers, front and back
// a load or clear completes once at the queue head; a query steps through every stored
// entry, with up to four products on the shift-add multiplier for candidates and a
// square root and a division on the root/divide unit for matches
// throughput: one command in the back end at a time, two-entry command queue in front
// results are registered strobes, never stalled; reset empties table, restores config
module cosine_similarity_pair_filter #(
	parameter int MAX_ENTRIES = 64,
	parameter int VECTOR_DIM  = 4,
	parameter int COMP_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [31:0]        user_id,
	input  logic signed [15:0] comp0,
	input  logic signed [15:0] comp1,
	input  logic signed [15:0] comp2,
	input  logic signed [15:0] comp3,
	input  logic [5:0]         row,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [14:0]        cfg_data,
	output logic               res_strobe,
	output logic [31:0]        row_user,
	output logic [31:0]        col_user,
	output logic [14:0]        cosine,
	output logic               valid_res,
	output logic               last
);
	import cspf_pkg::*;

	cmd_t cmd_in;
	cmd_t head;
	cfg_t cfg_q;
	res_t res;
	logic head_valid;
	logic pop;

	always_comb begin
		cmd_in.action  = action;
		cmd_in.user_id = user_id;
		cmd_in.comp[0] = comp0;
		cmd_in.comp[1] = comp1;
		cmd_in.comp[2] = comp2;
		cmd_in.comp[3] = comp3;
		cmd_in.row     = row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_threshold <= THR_RESET;
			cfg_q.exclude_bound   <= EXC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.match_threshold <= cfg_data;
				REG_EXCLUDE:   cfg_q.exclude_bound   <= cfg_data;
			endcase
		end
	end

	cspf_cmd_queue u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd_in    (cmd_in),
		.pop       (pop),
		.busy      (busy),
		.head_valid(head_valid),
		.head      (head)
	);

	cspf_exec #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.VECTOR_DIM (VECTOR_DIM),
		.COMP_BITS  (COMP_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.cfg       (cfg_q),
		.pop       (pop),
		.res_strobe(res_strobe),
		.res       (res)
	);

	assign row_user  = res.row_user;
	assign col_user  = res.col_user;
	assign cosine    = res.cosine;
	assign valid_res = res.valid_res;
	assign last      = res.last;

endmodule
